[rtl/i2a_pkg.sv]
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer to ascii converter
// Mode codes, ascii codes, the sequencer-to-datapath control struct and the
// digit-to-character mapping.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // mode codes
  localparam logic [1:0] MODE_DEC       = 2'd0;
  localparam logic [1:0] MODE_HEX_LOWER = 2'd1;
  localparam logic [1:0] MODE_HEX_UPPER = 2'd2;
  // bit of the mode that selects upper-case letters
  localparam int unsigned MODE_UPPER_BIT = 1;

  // ascii codes
  localparam logic [6:0] CHAR_MINUS   = 7'h2d;
  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;

  // control from the sequencer to the digit datapath
  typedef struct packed {
    logic load;       // take a new magnitude, clear the digits
    logic step;       // one shift-and-adjust step
    logic shift_out;  // drop the top digit
    logic hex;        // no decimal adjust
  } i2a_ctrl_t;

  // one digit value to its ascii character
  function automatic logic [6:0] digit_char(input logic [3:0] digit, input logic upper);
    logic [6:0] base;
    if (digit < 4'd10) begin
      digit_char = CHAR_ZERO + {3'b000, digit};
    end else begin
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      digit_char = base + {3'b000, digit - 4'd10};
    end
  endfunction

endpackage

[rtl/i2a_conv.sv]
// ----------------------------------------------------------------------------
// i2a_conv: shift-and-add-3 digit register
// Shifts the magnitude into a row of 4-bit digits one bit per step, with the
// add-3 adjust in decimal mode and none in hex mode, then hands the digits
// out from the top one at a time.
// ----------------------------------------------------------------------------
module i2a_conv #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned NUM_DIGITS  = 10
) (
  input  logic                   clk_i,
  input  i2a_pkg::i2a_ctrl_t     ctrl_i,
  input  logic [VALUE_WIDTH-1:0] mag_i,
  output logic [3:0]             top_digit_o
);

  localparam int unsigned DigW = 4 * NUM_DIGITS;

  logic [VALUE_WIDTH-1:0] mag_q;
  logic [DigW-1:0]        digits_q;
  logic [DigW-1:0]        adjusted;

  // add 3 to every digit of 5 or more before the shift (decimal only)
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (!ctrl_i.hex && (digits_q[4*i +: 4] >= 4'd5)) begin
        adjusted[4*i +: 4] = digits_q[4*i +: 4] + 4'd3;
      end else begin
        adjusted[4*i +: 4] = digits_q[4*i +: 4];
      end
    end
  end

  // magnitude and digit registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mag_q    <= mag_i;
      digits_q <= '0;
    end else if (ctrl_i.step) begin
      digits_q <= {adjusted[DigW-2:0], mag_q[VALUE_WIDTH-1]};
      mag_q    <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
    end else if (ctrl_i.shift_out) begin
      digits_q <= {digits_q[DigW-5:0], 4'h0};
    end
  end

  assign top_digit_o = digits_q[DigW-1 -: 4];

endmodule

[rtl/integer_to_ascii_digits.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: signed integer to decimal or hex ascii characters
// Takes a signed integer and a mode and sends its text one character per
// transaction, minus sign first when negative, with last on the final digit.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+-------------------------------
//   input   | in_valid_i  | in_stall_o  | mode_i, value_i
//   output  | out_valid_o | out_stall_i | character_o, last_o
//
// A number is accepted, then runs through shift-and-adjust steps in the
// shared digit register, then leading zeros are trimmed and the digits are sent,
// with a minus sign first when negative.
// in_stall_o stays high from the accept until the last character is loaded.
// Output stalls hold the character register and pause the sequencer in its sign and digit-sending states.
// Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [6:0]                    character_o,
  output logic                          last_o
);

  // digits for 2^(VALUE_WIDTH-1) in decimal, enough for hex too
  localparam int unsigned NumDigits = ((VALUE_WIDTH * 1233) / 4096) + 1;
  localparam int unsigned StepW     = $clog2(VALUE_WIDTH);
  localparam int unsigned DCntW     = $clog2(NumDigits + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_TRIM = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] step_cnt_q, step_cnt_d;
  logic [DCntW-1:0] dig_cnt_q, dig_cnt_d;
  logic             neg_q, neg_d;
  logic             hex_q, hex_d;
  logic             upper_q, upper_d;
  logic             out_valid_q, out_valid_d;
  logic [6:0]       char_q, char_d;
  logic             last_q, last_d;

  logic                   in_accept;
  logic                   out_free;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic [3:0]             top_digit;
  i2a_pkg::i2a_ctrl_t     ctrl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // magnitude as unsigned, exact for the most negative value
  assign in_neg = value_i[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~value_i + 1'b1) : value_i;

  // digit datapath
  i2a_conv #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NUM_DIGITS (NumDigits)
  ) u_conv (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .mag_i      (in_mag),
    .top_digit_o(top_digit)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_cnt_d  = step_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    neg_d       = neg_q;
    hex_d       = hex_q;
    upper_d     = upper_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    ctrl        = '0;
    ctrl.hex    = hex_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          ctrl.load  = 1'b1;
          neg_d      = in_neg;
          hex_d      = (mode_i != i2a_pkg::MODE_DEC);
          upper_d    = mode_i[i2a_pkg::MODE_UPPER_BIT];
          step_cnt_d = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.step  = 1'b1;
        step_cnt_d = step_cnt_q + 1'b1;
        if (step_cnt_q == StepW'(VALUE_WIDTH - 1)) begin
          dig_cnt_d = DCntW'(NumDigits);
          state_d   = ST_TRIM;
        end
      end
      // drop leading zeros, keep at least one digit
      ST_TRIM: begin
        if ((top_digit == 4'd0) && (dig_cnt_q > DCntW'(1))) begin
          ctrl.shift_out = 1'b1;
          dig_cnt_d      = dig_cnt_q - 1'b1;
        end else begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = i2a_pkg::CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          char_d         = i2a_pkg::digit_char(top_digit, upper_q);
          last_d         = (dig_cnt_q == DCntW'(1));
          ctrl.shift_out = 1'b1;
          dig_cnt_d      = dig_cnt_q - 1'b1;
          if (dig_cnt_q == DCntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_cnt_q  <= '0;
      dig_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_cnt_q  <= step_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // per-number flags and output character
  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    hex_q   <= hex_d;
    upper_q <= upper_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

[test/integer_to_ascii_digits_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_tb: self-checking bench of the integer to ascii converter
// Sends a table of directed numbers, then random numbers, under three idling
// patterns. Every character transaction is checked against a queue of expected
// characters filled by a behavioral formatter, or by the table's typed text.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_tb;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_NUMBERS = 200;
  localparam int DRAIN_CYCLES = 80;
  localparam int NUM_CASES = 22;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } char_beat_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] value;
    string       text;  // empty: expectation comes from the formatter
  } number_case_t;

  // directed numbers: zero, extremes, sign, digit boundaries and every mode
  number_case_t directed_cases [NUM_CASES] = '{
    '{i2a_pkg::MODE_DEC,       32'h0000_0000, "0"},
    '{i2a_pkg::MODE_HEX_LOWER, 32'h0000_0000, "0"},
    '{i2a_pkg::MODE_HEX_UPPER, 32'h0000_0000, "0"},
    '{i2a_pkg::MODE_DEC,       32'h7fff_ffff, "2147483647"},
    '{i2a_pkg::MODE_DEC,       32'h8000_0000, "-2147483648"},
    '{i2a_pkg::MODE_HEX_LOWER, 32'h7fff_ffff, "7fffffff"},
    '{i2a_pkg::MODE_HEX_UPPER, 32'h8000_0000, "-80000000"},
    '{i2a_pkg::MODE_HEX_LOWER, 32'h8000_0000, "-80000000"},
    '{i2a_pkg::MODE_DEC,       32'hffff_ffff, "-1"},
    '{i2a_pkg::MODE_HEX_UPPER, 32'hffff_ffff, "-1"},
    '{i2a_pkg::MODE_DEC,       32'h0000_0009, "9"},
    '{i2a_pkg::MODE_DEC,       32'h0000_000a, "10"},
    '{i2a_pkg::MODE_HEX_LOWER, 32'h0000_000f, "f"},
    '{i2a_pkg::MODE_HEX_UPPER, 32'h0000_0010, "10"},
    '{i2a_pkg::MODE_HEX_LOWER, 32'h00ab_cdef, "abcdef"},
    '{i2a_pkg::MODE_HEX_UPPER, 32'h00ab_cdef, "ABCDEF"},
    '{MODE_UNUSED,             32'h00ab_cdef, "ABCDEF"},
    '{MODE_UNUSED,             32'hedcb_5433, "-1234ABCD"},
    '{i2a_pkg::MODE_DEC,       32'h3b9a_ca00, "1000000000"},
    '{i2a_pkg::MODE_DEC,       32'hc465_3601, ""},
    '{i2a_pkg::MODE_DEC,       32'h5555_5555, ""},
    '{i2a_pkg::MODE_HEX_LOWER, 32'haaaa_aaaa, ""}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    mode_i = i2a_pkg::MODE_DEC;
  logic signed [VALUE_WIDTH-1:0] value_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [6:0]                    character_o;
  logic                          last_o;

  char_beat_t expected_chars [$];
  int         fail_count = 0;
  int         sender_idle_pct = 0;
  int         receiver_idle_pct = 0;

  integer_to_ascii_digits #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // formatter: queue the characters of one number, sign first
  function automatic void format_number(input logic [1:0] mode, input logic [31:0] value);
    logic [31:0] mag;
    logic        hex;
    logic        upper;
    logic [3:0]  digit;
    logic [6:0]  digit_chars [20];
    int          num_digits;
    hex = (mode != i2a_pkg::MODE_DEC);
    upper = mode[i2a_pkg::MODE_UPPER_BIT];
    // unsigned magnitude keeps the most negative value exact
    mag = value[31] ? (~value + 32'd1) : value;
    num_digits = 0;
    do begin
      if (hex) begin
        digit = mag[3:0];
        mag = mag >> 4;
      end else begin
        digit = 4'(mag % 32'd10);
        mag = mag / 32'd10;
      end
      if (digit < 4'd10) begin
        digit_chars[num_digits] = 7'("0") + 7'(digit);
      end else begin
        digit_chars[num_digits] = (upper ? 7'("A") : 7'("a")) + 7'(digit) - 7'd10;
      end
      num_digits++;
    end while (mag != 0);
    if (value[31]) begin
      expected_chars.push_back('{character: 7'("-"), last: 1'b0});
    end
    for (int i = num_digits - 1; i >= 0; i--) begin
      expected_chars.push_back('{character: digit_chars[i], last: (i == 0)});
    end
  endfunction

  // random value: full range, small, near powers of ten, or single bits or one below them, with random sign
  function automatic logic [31:0] random_value();
    logic [31:0] v;
    int          exponent;
    case ($urandom_range(3))
      0: begin
        v = $urandom;
      end
      1: begin
        v = $urandom_range(40);
      end
      2: begin
        v = 32'd1;
        exponent = $urandom_range(9);
        for (int i = 0; i < exponent; i++) v = v * 32'd10;
        v = v + 32'($urandom_range(2)) - 32'd1;
      end
      default: begin
        v = 32'd1 << $urandom_range(31);
        if ($urandom_range(1)) v = v - 32'd1;
      end
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // send one number and queue what it should print
  task automatic send_number(input logic [1:0] mode, input logic [31:0] value,
                             input string text);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // accepted at this edge
    if (text.len() > 0) begin
      for (int i = 0; i < text.len(); i++) begin
        expected_chars.push_back('{character: 7'(text[i]), last: (i == text.len() - 1)});
      end
    end else begin
      format_number(mode, value);
    end
  endtask

  // output side: check each character transaction, then pick the next stall
  always @(posedge clk_i) begin
    char_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character transaction: character %h, last %b",
               character_o, last_o);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (character_o !== want.character) begin
          $error("character: expected %h, actual %h", want.character, character_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, actual %b", want.last, last_o);
          fail_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  // stimulus
  initial begin
    sender_idle_pct = 24;
    receiver_idle_pct = 88;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NUM_CASES; i++) begin
      send_number(directed_cases[i].mode, directed_cases[i].value, directed_cases[i].text);
    end

    // random numbers under the three idling patterns
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i == RANDOM_NUMBERS / 3) begin
        sender_idle_pct = 88;
        receiver_idle_pct = 24;
      end else if (i == 2 * RANDOM_NUMBERS / 3) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      send_number(2'($urandom_range(3)), random_value(), "");
    end
    in_valid_i <= 1'b0;

    // drain
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // timeout
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/i2a_pkg.sv
rtl/i2a_conv.sv
rtl/integer_to_ascii_digits.sv
test/integer_to_ascii_digits_tb.sv
